// ===== hw/rtl/nit_pkg.sv =====
// shared constants and types of the noise-indexed threshold interpolator
// no dependencies; imported by the channel interfaces, nit_lane and the top level

package nit_pkg;

    localparam int TABLE_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 12;

    localparam int THR_W     = 12;   // one threshold
    localparam int THR_COUNT = 7;    // thresholds per table entry
    localparam int ENTRY_W   = 12;   // unscaled breakpoint
    localparam int IDX_W     = 4;    // entry index on the ports
    localparam int NOISE_W   = 16;   // query noise index, tenfold scale
    localparam int X_W       = 16;   // breakpoint times ten
    localparam int ROW_W     = ENTRY_W + THR_COUNT * THR_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_EN     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_RD_LO,
        ST_RD_HI,
        ST_TAKE_HI,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    // per-cycle commands from the sequencer to the threshold lanes
    typedef struct packed {
        logic take_lo;
        logic take_hi;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic zero_span;
    } t_lane_ctl;

endpackage

// ===== hw/rtl/nit_in_if.sv =====
// input channel of the interpolator: table writes and noise queries
// depends on nit_pkg

interface nit_in_if;
    import nit_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [ENTRY_W-1:0] entry_noise;
    logic [THR_W-1:0]   entry_spot_low;
    logic [THR_W-1:0]   entry_spot_high;
    logic [THR_W-1:0]   entry_spot;
    logic [THR_W-1:0]   entry_spot_strength;
    logic [THR_W-1:0]   entry_color_low_dot;
    logic [THR_W-1:0]   entry_color_low_line;
    logic [THR_W-1:0]   entry_color_high;
    logic [NOISE_W-1:0] query_noise;

    modport source (
        output valid, opcode, entry_index, entry_noise, entry_spot_low, entry_spot_high,
               entry_spot, entry_spot_strength, entry_color_low_dot, entry_color_low_line,
               entry_color_high, query_noise,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, entry_noise, entry_spot_low, entry_spot_high,
               entry_spot, entry_spot_strength, entry_color_low_dot, entry_color_low_line,
               entry_color_high, query_noise,
        output ready
    );

endinterface

// ===== hw/rtl/nit_out_if.sv =====
// output channel of the interpolator: interpolated thresholds and entries used
// depends on nit_pkg

interface nit_out_if;
    import nit_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] spot_low;
    logic [THR_W-1:0] spot_high;
    logic [THR_W-1:0] spot_level;
    logic [THR_W-1:0] spot_strength;
    logic [THR_W-1:0] color_low_dot;
    logic [THR_W-1:0] color_low_line;
    logic [THR_W-1:0] color_high;
    logic [IDX_W-1:0] lower_entry;
    logic [IDX_W-1:0] upper_entry;
    logic             enable_out;

    modport source (
        output valid, spot_low, spot_high, spot_level, spot_strength, color_low_dot,
               color_low_line, color_high, lower_entry, upper_entry, enable_out,
        input  ready
    );

    modport sink (
        input  valid, spot_low, spot_high, spot_level, spot_strength, color_low_dot,
               color_low_line, color_high, lower_entry, upper_entry, enable_out,
        output ready
    );

endinterface

// ===== hw/rtl/nit_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module nit_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/nit_lane.sv =====
// one threshold lane: bit-serial multiply of the y difference by the distance,
// then restoring division by the span, one quotient bit per cycle; uses nit_pkg

module nit_lane #(
    parameter int FRACTION_BITS = nit_pkg::FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  nit_pkg::t_lane_ctl        i_ctl,
    input  logic [nit_pkg::THR_W-1:0] i_y,
    input  logic [nit_pkg::X_W-1:0]   i_dist,
    input  logic [nit_pkg::X_W-1:0]   i_span,
    output logic [nit_pkg::THR_W-1:0] o_result
);
    import nit_pkg::*;

    localparam int PROD_W = THR_W + X_W;
    localparam int QW     = THR_W + FRACTION_BITS;

    logic [THR_W-1:0]  r_y1;
    logic              r_neg;
    logic [THR_W-1:0]  r_mag;
    logic [PROD_W-1:0] r_acc;
    logic [X_W-1:0]    r_rem;
    logic [QW-1:0]     r_dq;

    logic [PROD_W-1:0] n_acc;
    logic [X_W-1:0]    n_rem;
    logic [X_W:0]      rem_shift;
    logic [X_W:0]      rem_sub;
    logic              quo_bit;
    logic              y_below;
    logic [QW-1:0]     base;
    logic [QW-1:0]     combined;

    assign y_below = i_y < r_y1;

    // msb-first shift and add over the magnitude bits
    assign n_acc = {r_acc[PROD_W-2:0], 1'b0} + (r_mag[THR_W-1] ? PROD_W'(i_dist) : '0);

    // remainder stays below the span, so 17 bits cover the shifted value
    assign rem_shift = {r_rem, r_dq[QW-1]};
    assign rem_sub   = rem_shift - {1'b0, i_span};
    assign quo_bit   = rem_shift >= {1'b0, i_span};
    assign n_rem     = quo_bit ? rem_sub[X_W-1:0] : rem_shift[X_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_lo) begin
            r_y1 <= i_y;
        end
        if (i_ctl.take_hi) begin
            r_neg <= y_below;
            r_mag <= y_below ? (r_y1 - i_y) : (i_y - r_y1);
            r_acc <= '0;
        end else if (i_ctl.mul_step) begin
            r_acc <= n_acc;
            r_mag <= {r_mag[THR_W-2:0], 1'b0};
        end
        // dividend is product << fraction; its top part already sits below the span
        if (i_ctl.div_init) begin
            r_rem <= r_acc[PROD_W-1:THR_W];
            r_dq  <= {r_acc[THR_W-1:0], {FRACTION_BITS{1'b0}}};
        end else if (i_ctl.div_step) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[QW-2:0], quo_bit};
        end
    end

    // floor shift of y1 << f +/- q, kept modulo the 12 result bits
    assign base     = {r_y1, {FRACTION_BITS{1'b0}}};
    assign combined = r_neg ? (base - r_dq) : (base + r_dq);
    assign o_result = i_ctl.zero_span ? r_y1 : combined[QW-1:FRACTION_BITS];

endmodule

// ===== hw/rtl/noise_indexed_threshold_interpolator.sv =====
// top level: table ram, bracket search sequencer and seven threshold lanes
// depends on nit_pkg, nit_in_if, nit_out_if, nit_ram, nit_lane
// a write word is taken while idle; a query word runs through ST_FIRST, ST_LAST, the bracket
// scan in ST_SCAN (one table ram read per step), ST_RD_LO, ST_RD_HI and ST_TAKE_HI,
// then the multiply steps, ST_PREP and the divide steps in the lanes, and ST_DONE
// ST_DONE waits for a free output register; the next word is taken once back in idle
// reset: sequencer idle, no result pending, entry_count = 1, correction_enable = 0,
// table contents undefined until written (no clearing pass)

module noise_indexed_threshold_interpolator #(
    parameter int TABLE_DEPTH   = nit_pkg::TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS = nit_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nit_in_if.sink                         i_in,
    nit_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [nit_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nit_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nit_pkg::*;

    localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW       = THR_W + FRACTION_BITS;
    localparam int CNT_W    = $clog2(QW);
    localparam int MUL_LAST = THR_W - 1;
    localparam int DIV_LAST = QW - 1;

    function automatic logic [X_W-1:0] scale10(input logic [ENTRY_W-1:0] v);
        return X_W'({v, 3'b000}) + X_W'({v, 1'b0});
    endfunction

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_entry_count;
    logic                  r_corr_en;
    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_cnt;

    logic [NOISE_W-1:0] r_cur;
    logic [X_W-1:0]     r_xa;
    logic [X_W-1:0]     r_xlo;
    logic [X_W-1:0]     r_dist;
    logic [X_W-1:0]     r_span;
    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_lo;
    logic [AW-1:0]      r_hi;
    logic [THR_W-1:0]   r_thr [THR_COUNT];
    logic [IDX_W-1:0]   r_lower;
    logic [IDX_W-1:0]   r_upper;
    logic               r_enable;

    logic               in_acc;
    logic               query_acc;
    logic               ram_we;
    logic [ROW_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ROW_W-1:0]   ram_rdata;
    logic [X_W-1:0]     x_rd;
    logic [AW-1:0]      last_idx;
    logic [AW:0]        i_inc_wide;
    logic [AW-1:0]      i_inc;
    logic               below;
    logic               above;
    logic               between;
    logic               eq_a;
    logic               eq_b;
    logic               more;
    logic               out_free;
    logic               in_ready;
    t_lane_ctl          lane_ctl;
    logic [THR_W-1:0]   lane_res [THR_COUNT];

    assign in_acc    = i_in.valid && in_ready;
    assign query_acc = in_acc && (i_in.opcode == OP_QUERY);
    assign ram_we    = in_acc && (i_in.opcode == OP_WRITE)
                       && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign ram_wdata = {i_in.entry_color_high, i_in.entry_color_low_line,
                        i_in.entry_color_low_dot, i_in.entry_spot_strength, i_in.entry_spot,
                        i_in.entry_spot_high, i_in.entry_spot_low, i_in.entry_noise};
    assign i_in.ready = in_ready;

    nit_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign x_rd = scale10(ram_rdata[ENTRY_W-1:0]);

    // entry count of zero acts as one, beyond the table as the table depth
    always_comb begin
        if (r_entry_count == '0) begin
            last_idx = '0;
        end else if (32'(r_entry_count) > TABLE_DEPTH) begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end else begin
            last_idx = AW'(r_entry_count - CFG_DATA_W'(1));
        end
    end

    // search flags: r_xa holds breakpoint i scaled, the ram word is breakpoint i+1
    assign i_inc_wide = {1'b0, r_i} + (AW + 1)'(1);
    assign i_inc      = i_inc_wide[AW-1:0];
    assign below      = r_cur <= r_xa;
    assign above      = r_cur >= x_rd;
    assign between    = (r_xa < r_cur) && (r_cur < x_rd);
    assign eq_a       = r_cur == r_xa;
    assign eq_b       = r_cur == x_rd;
    assign more       = i_inc_wide < {1'b0, last_idx};
    assign out_free   = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (query_acc) n_state = ST_FIRST;
            end
            ST_FIRST:   n_state = ST_LAST;
            ST_LAST: begin
                n_state = (below || above) ? ST_RD_LO : ST_SCAN;
            end
            ST_SCAN: begin
                if (between || eq_a || eq_b || !more) n_state = ST_RD_LO;
            end
            ST_RD_LO:   n_state = ST_RD_HI;
            ST_RD_HI:   n_state = ST_TAKE_HI;
            ST_TAKE_HI: n_state = ST_MUL;
            ST_MUL: begin
                if (r_cnt == CNT_W'(MUL_LAST)) n_state = ST_PREP;
            end
            ST_PREP:    n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_LAST)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: ram read address, input ready, lane commands
    always_comb begin
        in_ready  = 1'b0;
        ram_raddr = '0;
        lane_ctl  = '0;
        unique case (r_state)
            ST_IDLE:    in_ready = 1'b1;
            ST_FIRST:   ram_raddr = last_idx;
            ST_LAST:    ram_raddr = AW'(1);
            ST_SCAN:    ram_raddr = r_i + AW'(2);
            ST_RD_LO:   ram_raddr = r_lo;
            ST_RD_HI: begin
                ram_raddr        = r_hi;
                lane_ctl.take_lo = 1'b1;
            end
            ST_TAKE_HI: lane_ctl.take_hi  = 1'b1;
            ST_MUL:     lane_ctl.mul_step = 1'b1;
            ST_PREP:    lane_ctl.div_init = 1'b1;
            ST_DIV:     lane_ctl.div_step = 1'b1;
            ST_DONE:    ;
            default:    ;
        endcase
        lane_ctl.zero_span = (r_lo == r_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= CFG_DATA_W'(1);
            r_corr_en     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                    CFG_CORR_EN:     r_corr_en     <= i_cfg_data[0];
                    default:         ;
                endcase
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == ST_MUL && r_cnt != CNT_W'(MUL_LAST)) || r_state == ST_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (query_acc) r_cur <= i_in.query_noise;
            end
            ST_FIRST: r_xa <= x_rd;
            ST_LAST: begin
                priority if (below) begin
                    r_lo <= '0;
                    r_hi <= '0;
                end else if (above) begin
                    r_lo <= last_idx;
                    r_hi <= last_idx;
                end else begin
                    r_i <= '0;
                end
            end
            ST_SCAN: begin
                priority if (between) begin
                    r_lo <= r_i;
                    r_hi <= i_inc;
                end else if (eq_a) begin
                    r_lo <= r_i;
                    r_hi <= r_i;
                end else if (eq_b) begin
                    r_lo <= i_inc;
                    r_hi <= i_inc;
                end else if (more) begin
                    r_xa <= x_rd;
                    r_i  <= i_inc;
                end else begin
                    // unsorted table with no bracket falls back to entry 0
                    r_lo <= '0;
                    r_hi <= '0;
                end
            end
            ST_RD_HI: r_xlo <= x_rd;
            ST_TAKE_HI: begin
                r_span <= x_rd - r_xlo;
                r_dist <= r_cur - r_xlo;
            end
            ST_DONE: begin
                if (out_free) begin
                    for (int k = 0; k < THR_COUNT; k++) begin
                        r_thr[k] <= lane_res[k];
                    end
                    r_lower  <= IDX_W'(r_lo);
                    r_upper  <= IDX_W'(r_hi);
                    r_enable <= r_corr_en;
                end
            end
            default: ;
        endcase
    end

    for (genvar k = 0; k < THR_COUNT; k++) begin : g_lane
        nit_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_y      (ram_rdata[ENTRY_W + k*THR_W +: THR_W]),
            .i_dist   (r_dist),
            .i_span   (r_span),
            .o_result (lane_res[k])
        );
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.spot_low       = r_thr[0];
    assign o_out.spot_high      = r_thr[1];
    assign o_out.spot_level     = r_thr[2];
    assign o_out.spot_strength  = r_thr[3];
    assign o_out.color_low_dot  = r_thr[4];
    assign o_out.color_low_line = r_thr[5];
    assign o_out.color_high     = r_thr[6];
    assign o_out.lower_entry    = r_lower;
    assign o_out.upper_entry    = r_upper;
    assign o_out.enable_out     = r_enable;

endmodule
